### hdl/get_pkg.sv
`default_nettype none

package get_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int SIZE_W = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 3);

   localparam int CFG_W   = 11;
   localparam int CIDX_W  = 2;
   localparam int PIX_W   = 8;
   localparam int MAG_W   = 17;
   localparam int SQ_W    = 16;
   localparam int DIR_W   = 2;
   localparam int PROD_W  = 25;
   localparam int TAN_W   = 17;
   localparam int TAN_FRAC = 15;

   localparam logic [TAN_W-1:0] TAN_LOW_Q15  = 17'd13573;
   localparam logic [TAN_W-1:0] TAN_HIGH_Q15 = 17'd79109;

   localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CIDX_W-1:0] REG_BORDER_VALUE = 2'd2;

   localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

   localparam logic [DIR_W-1:0] SEC_H    = 2'd0;
   localparam logic [DIR_W-1:0] SEC_D45  = 2'd1;
   localparam logic [DIR_W-1:0] SEC_V    = 2'd2;
   localparam logic [DIR_W-1:0] SEC_D135 = 2'd3;

   typedef struct packed {
      logic [COL_W-1:0] x;
      logic             slot;
      logic             emit;
      logic             fend;
      logic [COL_W-1:0] ox;
      logic [ROW_W-1:0] oy;
      logic             lok;
      logic             rok;
      logic             tok;
      logic             bok;
   } meta_type;

   typedef struct packed {
      meta_type         meta;
      logic [PIX_W-1:0] pd;
      logic             wr;
      logic             usel;
      logic             lsel;
      logic             lone;
      logic             rsel;
      logic             mrow;
   } acc_type;

   typedef struct packed {
      logic [MAG_W-1:0] top;
      logic [MAG_W-1:0] mid;
      logic [MAG_W-1:0] bot;
      logic [DIR_W-1:0] dir;
   } win_col_type;

   typedef win_col_type [2:0] win_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (SIZE_W'(v) > hi) begin
         r = hi;
      end else begin
         r = SIZE_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/get_intf.sv
`default_nettype none

interface get_req_if;
   import get_pkg::*;
   logic             valid;
   logic             ready;
   logic             mode;
   logic [PIX_W-1:0] pixel;
   modport source(output valid, mode, pixel, input ready);
   modport sink(input valid, mode, pixel, output ready);
endinterface

interface get_rsp_if;
   import get_pkg::*;
   logic             valid;
   logic             ready;
   logic             edge_res;
   logic [COL_W-1:0] column;
   logic [ROW_W-1:0] row;
   logic             frame_end;
   modport source(output valid, edge_res, column, row, frame_end, input ready);
   modport sink(input valid, edge_res, column, row, frame_end, output ready);
endinterface

interface get_csr_if;
   import get_pkg::*;
   logic              valid;
   logic              ready;
   logic [CIDX_W-1:0] index;
   logic [CFG_W-1:0]  data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### hdl/get_grad.sv
`default_nettype none

module get_grad (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        pipe_en,
   input  wire logic                        acc_valid,
   input  wire get_pkg::acc_type            acc,
   input  wire logic [get_pkg::PIX_W-1:0]   border,
   output logic                             g_valid,
   output get_pkg::meta_type                g_meta,
   output logic [get_pkg::MAG_W-1:0]        g_mag,
   output logic [get_pkg::DIR_W-1:0]        g_dir
);
   import get_pkg::*;

   logic [PIX_W-1:0] pix_mem_ff [0:2*MAX_WIDTH-1];
   logic [PIX_W-1:0] rda_ff, rdb_ff;
   logic [COL_W-1:0] xp1;

   logic             s1_valid_ff;
   acc_type          s1_acc_ff;
   logic [PIX_W-1:0] prev1_ff, prev2_ff, row0_cur_ff, row0_prev_ff;

   logic [PIX_W-1:0] pu, pl, pr;
   logic signed [PIX_W:0] dx, dy, fdx, fdy, adx;
   logic             neg;
   logic [PIX_W-1:0] ax, ay;
   logic             dxpos;

   logic              s2_valid_ff;
   meta_type          s2_meta_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [PROD_W-1:0] lowp_ff, highp_ff, lowp_in, highp_in, lhs;
   logic [PIX_W-1:0]  ay_ff;
   logic              dxpos_ff, mrow_ff;

   assign xp1 = acc.meta.x + COL_W'(1);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rda_ff <= pix_mem_ff[{~acc.meta.slot, xp1}];
         rdb_ff <= pix_mem_ff[{acc.meta.slot, acc.meta.x}];
         if (acc_valid && acc.wr) begin
            pix_mem_ff[{acc.meta.slot, acc.meta.x}] <= acc.pd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= acc_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_acc_ff <= acc;
         if (s1_valid_ff) begin
            prev1_ff <= rda_ff;
            prev2_ff <= prev1_ff;
            if (s1_acc_ff.meta.x == '0) begin
               row0_prev_ff <= row0_cur_ff;
               row0_cur_ff  <= s1_acc_ff.pd;
            end
         end
      end
   end

   always_comb begin
      pu = s1_acc_ff.usel ? rdb_ff : border;
      pr = s1_acc_ff.rsel ? rda_ff : border;
      if (!s1_acc_ff.lsel) begin
         pl = border;
      end else if (s1_acc_ff.lone) begin
         pl = row0_prev_ff;
      end else begin
         pl = prev2_ff;
      end
      dx    = $signed({1'b0, pr}) - $signed({1'b0, pl});
      dy    = $signed({1'b0, s1_acc_ff.pd}) - $signed({1'b0, pu});
      neg   = dy[PIX_W];
      fdx   = neg ? -dx : dx;
      fdy   = neg ? -dy : dy;
      adx   = fdx[PIX_W] ? -fdx : fdx;
      ax    = adx[PIX_W-1:0];
      ay    = fdy[PIX_W-1:0];
      dxpos = !fdx[PIX_W] && (fdx != '0);
      sqx_in   = SQ_W'(ax) * SQ_W'(ax);
      sqy_in   = SQ_W'(ay) * SQ_W'(ay);
      lowp_in  = PROD_W'(ax) * PROD_W'(TAN_LOW_Q15);
      highp_in = PROD_W'(ax) * PROD_W'(TAN_HIGH_Q15);
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_meta_ff <= s1_acc_ff.meta;
         sqx_ff     <= sqx_in;
         sqy_ff     <= sqy_in;
         lowp_ff    <= lowp_in;
         highp_ff   <= highp_in;
         ay_ff      <= ay;
         dxpos_ff   <= dxpos;
         mrow_ff    <= s1_acc_ff.mrow;
      end
   end

   assign lhs = PROD_W'(ay_ff) << TAN_FRAC;

   always_comb begin
      if (!mrow_ff) begin
         g_mag = '0;
         g_dir = SEC_H;
      end else begin
         g_mag = MAG_W'(sqx_ff) + MAG_W'(sqy_ff);
         if (lhs <= lowp_ff) begin
            g_dir = SEC_H;
         end else if (lhs > highp_ff) begin
            g_dir = SEC_V;
         end else if (dxpos_ff) begin
            g_dir = SEC_D45;
         end else begin
            g_dir = SEC_D135;
         end
      end
   end

   assign g_valid = s2_valid_ff;
   assign g_meta  = s2_meta_ff;

endmodule

`default_nettype wire

### hdl/get_window.sv
`default_nettype none

module get_window (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        pipe_en,
   input  wire logic                        g_valid,
   input  wire get_pkg::meta_type           g_meta,
   input  wire logic [get_pkg::MAG_W-1:0]   g_mag,
   input  wire logic [get_pkg::DIR_W-1:0]   g_dir,
   output logic                             w_valid,
   output get_pkg::meta_type                w_meta,
   output get_pkg::win_type                 win
);
   import get_pkg::*;

   logic [MAG_W-1:0] mag_mem_ff [0:2*MAX_WIDTH-1];
   logic [DIR_W-1:0] dir_mem_ff [0:MAX_WIDTH-1];

   logic             s3_valid_ff, s4_valid_ff;
   meta_type         s3_meta_ff, s4_meta_ff;
   logic [MAG_W-1:0] s3_mag_ff, top_rd_ff, mid_rd_ff;
   logic [DIR_W-1:0] s3_dir_ff, dir_rd_ff;
   win_type          win_ff;
   win_col_type      nc;
   logic             same_x, fwd_top, fwd_mid, fwd_dir;

   // The item one stage ahead writes back in the same cycle; its values are forwarded.
   assign same_x  = s3_valid_ff && (g_meta.x == s3_meta_ff.x);
   assign fwd_top = same_x && (g_meta.slot == s3_meta_ff.slot);
   assign fwd_mid = same_x && (g_meta.slot != s3_meta_ff.slot);
   assign fwd_dir = same_x;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         top_rd_ff <= fwd_top ? s3_mag_ff : mag_mem_ff[{~g_meta.slot, g_meta.x}];
         mid_rd_ff <= fwd_mid ? s3_mag_ff : mag_mem_ff[{g_meta.slot, g_meta.x}];
         dir_rd_ff <= fwd_dir ? s3_dir_ff : dir_mem_ff[g_meta.x];
         if (s3_valid_ff) begin
            mag_mem_ff[{~s3_meta_ff.slot, s3_meta_ff.x}] <= s3_mag_ff;
            dir_mem_ff[s3_meta_ff.x] <= s3_dir_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_valid_ff <= g_valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_comb begin
      nc.top = top_rd_ff;
      nc.mid = mid_rd_ff;
      nc.bot = s3_mag_ff;
      nc.dir = dir_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_meta_ff <= g_meta;
         s3_mag_ff  <= g_mag;
         s3_dir_ff  <= g_dir;
         s4_meta_ff <= s3_meta_ff;
         if (s3_valid_ff) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= nc;
         end
      end
   end

   assign w_valid = s4_valid_ff;
   assign w_meta  = s4_meta_ff;
   assign win     = win_ff;

endmodule

`default_nettype wire

### hdl/get_nms.sv
`default_nettype none

module get_nms (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              w_valid,
   input  wire get_pkg::meta_type w_meta,
   input  wire get_pkg::win_type  win,
   output logic                   pipe_en,
   get_rsp_if.source              rsp
);
   import get_pkg::*;

   logic             rsp_valid_ff;
   logic             edge_ff, edge_in;
   logic [COL_W-1:0] column_ff;
   logic [ROW_W-1:0] row_ff;
   logic             fend_ff;
   logic [MAG_W-1:0] m, m1, m2;

   assign pipe_en = !rsp_valid_ff || rsp.ready;

   always_comb begin
      m = win[1].mid;
      case (win[1].dir)
         SEC_H: begin
            m1 = w_meta.lok ? win[0].mid : '0;
            m2 = w_meta.rok ? win[2].mid : '0;
         end
         SEC_D45: begin
            m1 = (w_meta.lok && w_meta.tok) ? win[0].top : '0;
            m2 = (w_meta.rok && w_meta.bok) ? win[2].bot : '0;
         end
         SEC_V: begin
            m1 = w_meta.tok ? win[1].top : '0;
            m2 = w_meta.bok ? win[1].bot : '0;
         end
         default: begin
            m1 = (w_meta.rok && w_meta.tok) ? win[2].top : '0;
            m2 = (w_meta.lok && w_meta.bok) ? win[0].bot : '0;
         end
      endcase
      edge_in = (m > m1) && (m > m2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= w_valid && w_meta.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         edge_ff   <= edge_in;
         column_ff <= w_meta.ox;
         row_ff    <= w_meta.oy;
         fend_ff   <= w_meta.fend;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.edge_res  = edge_ff;
   assign rsp.column    = column_ff;
   assign rsp.row       = row_ff;
   assign rsp.frame_end = fend_ff;

endmodule

`default_nettype wire

### hdl/gradient_edge_thinning_top.sv
`default_nettype none

// Non-maximum suppression of a central-difference gradient over a raster pixel stream. One beat
// is taken per clock whenever the result side is not stalled. A beat that produces a result
// presents it on the result port after the grad, window and output stages. The result for a pixel
// comes with the input beat 2W+1 positions after it, so after the last pixel of a frame 2W+1
// further beats (drain or pixel) flush the last rows. A drain beat while pixels of the frame are
// still expected is accepted and discarded. The rate is set by the single read-modify-write pass
// per beat through the pixel line memory and the magnitude and sector line memories, with
// write-back forwarding between neighboring beats. Line memories need no clearing after reset.
// Configuration writes restart the frame and must only be issued while the block is idle.
module gradient_edge_thinning_top (
   input wire logic   clock,
   input wire logic   reset,
   get_req_if.sink    req_bus,
   get_rsp_if.source  rsp_bus,
   get_csr_if.sink    csr_bus
);
   import get_pkg::*;

   logic [SIZE_W-1:0] w_ff, h_ff;
   logic [PIX_W-1:0]  bv_ff;
   logic [COL_W-1:0]  x_ff, x_in;
   logic [SIZE_W-1:0] y_ff, y_in;

   logic              pipe_en, take, cfg_hit;
   logic [SIZE_W-1:0] xe, xp1, ox_full, oy_full;
   logic              real_row, last_col;
   acc_type           acc;

   logic              g_valid, w_valid;
   meta_type          g_meta, w_meta;
   logic [MAG_W-1:0]  g_mag;
   logic [DIR_W-1:0]  g_dir;
   win_type           win;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = pipe_en;

   assign cfg_hit = csr_bus.valid && ((csr_bus.index == REG_FRAME_WIDTH) ||
                    (csr_bus.index == REG_FRAME_HEIGHT) || (csr_bus.index == REG_BORDER_VALUE));

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff  <= RESET_WIDTH;
         h_ff  <= RESET_HEIGHT;
         bv_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_FRAME_WIDTH:  w_ff  <= clamp_size(csr_bus.data, SIZE_W'(MAX_WIDTH));
            REG_FRAME_HEIGHT: h_ff  <= clamp_size(csr_bus.data, SIZE_W'(MAX_HEIGHT));
            REG_BORDER_VALUE: bv_ff <= csr_bus.data[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      xe       = SIZE_W'(x_ff);
      xp1      = xe + SIZE_W'(1);
      real_row = y_ff < h_ff;
      last_col = xp1 >= w_ff;
      ox_full  = (x_ff == '0) ? w_ff - SIZE_W'(1) : xe - SIZE_W'(1);
      oy_full  = (x_ff == '0) ? y_ff - SIZE_W'(3) : y_ff - SIZE_W'(2);

      acc.meta.x    = x_ff;
      acc.meta.slot = y_ff[0];
      acc.meta.emit = (y_ff > SIZE_W'(2)) || ((y_ff == SIZE_W'(2)) && (x_ff != '0));
      acc.meta.fend = (x_ff == '0) && (y_ff == h_ff + SIZE_W'(2));
      acc.meta.ox   = ox_full[COL_W-1:0];
      acc.meta.oy   = oy_full[ROW_W-1:0];
      acc.meta.lok  = ox_full != '0;
      acc.meta.rok  = (ox_full + SIZE_W'(1)) < w_ff;
      acc.meta.tok  = oy_full != '0;
      acc.meta.bok  = (oy_full + SIZE_W'(1)) < h_ff;
      acc.pd        = real_row ? req_bus.pixel : bv_ff;
      acc.wr        = real_row;
      acc.usel      = y_ff >= SIZE_W'(2);
      acc.lsel      = x_ff != '0;
      acc.lone      = x_ff == COL_W'(1);
      acc.rsel      = xp1 < w_ff;
      acc.mrow      = (y_ff != '0) && ((y_ff - SIZE_W'(1)) < h_ff);

      take = req_bus.valid && pipe_en && !(real_row && req_bus.mode);

      x_in = x_ff;
      y_in = y_ff;
      if (cfg_hit) begin
         x_in = '0;
         y_in = '0;
      end else if (take) begin
         if (acc.meta.fend) begin
            x_in = '0;
            y_in = '0;
         end else if (last_col) begin
            x_in = '0;
            y_in = y_ff + SIZE_W'(1);
         end else begin
            x_in = x_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   get_grad u_grad (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .acc_valid (take),
      .acc       (acc),
      .border    (bv_ff),
      .g_valid   (g_valid),
      .g_meta    (g_meta),
      .g_mag     (g_mag),
      .g_dir     (g_dir)
   );

   get_window u_window (
      .clock   (clock),
      .reset   (reset),
      .pipe_en (pipe_en),
      .g_valid (g_valid),
      .g_meta  (g_meta),
      .g_mag   (g_mag),
      .g_dir   (g_dir),
      .w_valid (w_valid),
      .w_meta  (w_meta),
      .win     (win)
   );

   get_nms u_nms (
      .clock   (clock),
      .reset   (reset),
      .w_valid (w_valid),
      .w_meta  (w_meta),
      .win     (win),
      .pipe_en (pipe_en),
      .rsp     (rsp_bus)
   );

endmodule

`default_nettype wire

### tb/gradient_edge_thinning_checker.sv
`default_nettype none

module gradient_edge_thinning_checker (
   input wire logic clock,
   input wire logic reset,
   get_req_if       req,
   get_rsp_if       rsp,
   get_csr_if       csr,
   output int       fail_count,
   output int       pending
);
   import get_pkg::*;

   typedef struct {
      logic             is_edge;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             frame_end;
   } thin_mark_type;

   thin_mark_type     expected_marks[$];

   logic [PIX_W-1:0]  pixel_rows[2][MAX_WIDTH];
   logic [MAG_W-1:0]  mag_rows[2][MAX_WIDTH];
   logic [DIR_W-1:0]  dir_row[MAX_WIDTH];
   logic [MAG_W-1:0]  win_top[3], win_mid[3], win_bot[3];
   logic [DIR_W-1:0]  win_dir[3];
   logic [CFG_W-1:0]  width_reg, height_reg;
   logic [PIX_W-1:0]  border_reg;
   int unsigned       in_col, in_row, out_col, out_row;

   assign pending = expected_marks.size();

   initial begin
      fail_count = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         pixel_rows[0][i] = '0;
         pixel_rows[1][i] = '0;
         mag_rows[0][i] = '0;
         mag_rows[1][i] = '0;
         dir_row[i] = SEC_H;
      end
      for (int i = 0; i < 3; i++) begin
         win_top[i] = '0;
         win_mid[i] = '0;
         win_bot[i] = '0;
         win_dir[i] = SEC_H;
      end
   end

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
      if (v == '0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [DIR_W-1:0] gradient_sector(input int dx, input int dy);
      longint unsigned ax, lhs;
      if (dy < 0) begin
         dx = -dx;
         dy = -dy;
      end
      ax = (dx < 0) ? -dx : dx;
      lhs = longint'(dy) << TAN_FRAC;
      if (lhs <= ax * TAN_LOW_Q15) return SEC_H;
      if (lhs > ax * TAN_HIGH_Q15) return SEC_V;
      return (dx > 0) ? SEC_D45 : SEC_D135;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic thin_pixel(input logic mode, input logic [PIX_W-1:0] pix);
      int unsigned w, h, x, y, t, ox, oy;
      logic        in_frame, mag_row, lok, rok, tok, bok, fend;
      int          pu, pd, pl, pr, dx, dy;
      logic [MAG_W-1:0] mag, m1, m2;
      logic [DIR_W-1:0] dir;
      thin_mark_type mark;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      x = in_col;
      y = in_row;
      in_frame = y < h;
      mag_row = y >= 1 && y - 1 < h;
      mag = '0;
      dir = SEC_H;
      if (in_frame && mode) return;
      if (x >= w) x = 0;
      if (mag_row) begin
         pu = (y >= 2) ? pixel_rows[y & 1][x] : border_reg;
         pd = in_frame ? pix : border_reg;
         pl = (x >= 1) ? pixel_rows[(y + 1) & 1][x - 1] : border_reg;
         pr = (x + 1 < w) ? pixel_rows[(y + 1) & 1][x + 1] : border_reg;
         dx = pr - pl;
         dy = pd - pu;
         mag = MAG_W'(dx * dx + dy * dy);
         dir = gradient_sector(dx, dy);
      end
      for (int i = 0; i < 2; i++) begin
         win_top[i] = win_top[i+1];
         win_mid[i] = win_mid[i+1];
         win_bot[i] = win_bot[i+1];
         win_dir[i] = win_dir[i+1];
      end
      win_top[2] = mag_rows[(y + 1) & 1][x];
      win_mid[2] = mag_rows[y & 1][x];
      win_bot[2] = mag;
      win_dir[2] = dir_row[x];
      if (in_frame) pixel_rows[y & 1][x] = pix;
      mag_rows[(y + 1) & 1][x] = mag;
      dir_row[x] = dir;
      t = y * w + x;
      if (x + 1 >= w) begin
         in_col = 0;
         in_row = y + 1;
      end else begin
         in_col = x + 1;
      end
      if (t < 2 * w + 1) return;
      ox = out_col;
      oy = out_row;
      lok = ox > 0;
      rok = ox + 1 < w;
      tok = oy > 0;
      bok = oy + 1 < h;
      fend = ox + 1 >= w && oy + 1 >= h;
      case (win_dir[1])
         SEC_H: begin
            m1 = lok ? win_mid[0] : '0;
            m2 = rok ? win_mid[2] : '0;
         end
         SEC_D45: begin
            m1 = (lok && tok) ? win_top[0] : '0;
            m2 = (rok && bok) ? win_bot[2] : '0;
         end
         SEC_V: begin
            m1 = tok ? win_top[1] : '0;
            m2 = bok ? win_bot[1] : '0;
         end
         default: begin
            m1 = (rok && tok) ? win_top[2] : '0;
            m2 = (lok && bok) ? win_bot[0] : '0;
         end
      endcase
      mark.is_edge = win_mid[1] > m1 && win_mid[1] > m2;
      mark.column = COL_W'(ox);
      mark.row = ROW_W'(oy);
      mark.frame_end = fend;
      expected_marks.push_back(mark);
      if (fend) begin
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
      end else if (ox + 1 >= w) begin
         out_col = 0;
         out_row = oy + 1;
      end else begin
         out_col = ox + 1;
      end
   endtask

   always @(posedge clock) begin
      thin_mark_type want;
      if (reset) begin
         width_reg = CFG_W'(640);
         height_reg = CFG_W'(480);
         border_reg = '0;
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == REG_FRAME_WIDTH || csr.index == REG_FRAME_HEIGHT ||
                csr.index == REG_BORDER_VALUE) begin
               if (csr.index == REG_FRAME_WIDTH) width_reg = csr.data;
               if (csr.index == REG_FRAME_HEIGHT) height_reg = csr.data;
               if (csr.index == REG_BORDER_VALUE) border_reg = csr.data[PIX_W-1:0];
               in_col = 0;
               in_row = 0;
               out_col = 0;
               out_row = 0;
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_marks.size() == 0) begin
               report("unexpected result beat, row", rsp.row, -1);
            end else begin
               want = expected_marks.pop_front();
               if (rsp.edge_res !== want.is_edge) report("edge_res", rsp.edge_res, want.is_edge);
               if (rsp.column !== want.column) report("column", rsp.column, want.column);
               if (rsp.row !== want.row) report("row", rsp.row, want.row);
               if (rsp.frame_end !== want.frame_end)
                  report("frame_end", rsp.frame_end, want.frame_end);
            end
         end
         if (req.valid && req.ready) thin_pixel(req.mode, req.pixel);
      end
   end

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
   import get_pkg::*;

   localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;
   localparam int IDLE_LIMIT = 20000;

   logic clock;
   logic reset;
   int   fail_count, pending, beats, quiet, gap_pct, stall_left;
   int unsigned cur_w, cur_h;
   logic rsp_bursty;

   get_req_if req_bus();
   get_rsp_if rsp_bus();
   get_csr_if csr_bus();

   gradient_edge_thinning_top uut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   gradient_edge_thinning_checker checker_i (
      .clock(clock), .reset(reset), .req(req_bus), .rsp(rsp_bus), .csr(csr_bus),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r >= gap_pct) return 0;
      if (r % 10 == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!rsp_bursty && $urandom_range(0, 99) < 25) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : 0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet <= 0;
      end else if (quiet >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic put_beat(input logic m, input logic [PIX_W-1:0] p);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         req_bus.mode <= 1'($urandom_range(0, 1));
         req_bus.pixel <= PIX_W'($urandom_range(0, 255));
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.mode <= m;
      req_bus.pixel <= p;
      do @(negedge clock); while (!req_bus.ready);
      @(posedge clock);
      beats++;
   endtask

   task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      do @(negedge clock); while (!csr_bus.ready);
      @(posedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [PIX_W-1:0] border);
      settle();
      write_reg(REG_FRAME_WIDTH, w);
      write_reg(REG_FRAME_HEIGHT, h);
      write_reg(REG_BORDER_VALUE, {3'b000, border});
      if ($urandom_range(0, 5) == 0) write_reg(REG_SPARE, CFG_W'($urandom_range(0, 2047)));
      csr_bus.valid <= 1'b0;
      cur_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
      cur_h = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
   endtask

   // Pixel patterns: noise, a tilted step edge, or a ramp, so that every sector shows up.
   task automatic run_frame(input int style, input int rows_sent);
      logic [PIX_W-1:0] lo, hi, p;
      int kink;
      lo = PIX_W'($urandom_range(0, 255));
      hi = PIX_W'($urandom_range(0, 255));
      kink = $urandom_range(0, cur_w + cur_h);
      for (int r = 0; r < rows_sent; r++) begin
         for (int c = 0; c < cur_w; c++) begin
            if ($urandom_range(0, 15) == 0) put_beat(1'b1, PIX_W'($urandom_range(0, 255)));
            case (style)
               0: p = PIX_W'($urandom_range(0, 255));
               1: p = (c + 2 * r > kink) ? hi : lo;
               default: p = PIX_W'(lo + c * (hi % 7) + r * (lo % 5));
            endcase
            put_beat(1'b0, p);
         end
      end
      if (rows_sent == cur_h) begin
         for (int i = 0; i < 2 * cur_w + 1; i++) begin
            put_beat(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      beats = 0;
      quiet = 0;
      gap_pct = 30;
      rsp_bursty = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.mode = 1'b0;
      req_bus.pixel = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_FRAME_WIDTH;
      csr_bus.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frame with full-scale values, a drain mid-frame and pixels during the flush.
      set_frame(11'd3, 11'd3, 8'hFF);
      put_beat(1'b0, 8'h00);
      put_beat(1'b1, 8'hFF);
      put_beat(1'b0, 8'hFF);
      put_beat(1'b0, 8'h00);
      put_beat(1'b0, 8'hFF);
      put_beat(1'b0, 8'h00);
      put_beat(1'b0, 8'hFF);
      put_beat(1'b0, 8'h00);
      put_beat(1'b0, 8'hFF);
      put_beat(1'b0, 8'h80);
      for (int i = 0; i < 7; i++) put_beat(i[0], 8'hAA);
      set_frame(11'd0, 11'd0, 8'h00);
      put_beat(1'b0, 8'hFF);
      put_beat(1'b1, 8'h00);
      put_beat(1'b0, 8'h55);
      put_beat(1'b1, 8'h00);
      set_frame(11'd2, 11'd1, 8'h7F);
      run_frame(0, 1);

      // Clamped frame height, a full frame of the tallest size.
      set_frame(11'd1, 11'd2047, PIX_W'($urandom_range(0, 255)));
      run_frame(2, cur_h);

      while (beats < 1650) begin
         gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 50);
         rsp_bursty = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) == 0)
            set_frame(CFG_W'($urandom_range(13, 64)), CFG_W'($urandom_range(1, 4)),
                      PIX_W'($urandom_range(0, 255)));
         else
            set_frame(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 8)),
                      PIX_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 7) == 0) begin
            run_frame($urandom_range(0, 2), $urandom_range(0, cur_h - 1));
         end else begin
            repeat ($urandom_range(1, 3)) run_frame($urandom_range(0, 2), cur_h);
         end
      end

      req_bus.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
hdl/get_pkg.sv
hdl/get_intf.sv
hdl/get_grad.sv
hdl/get_window.sv
hdl/get_nms.sv
hdl/gradient_edge_thinning_top.sv
tb/gradient_edge_thinning_checker.sv
tb/tb_top.sv
